FILE: rtl/sfp_pkg.sv
// Shared constants, types and the header helper function of the serial provisioning frame parser.
package sfp_pkg;

   localparam int MAX_PAYLOAD_DEF = 32;
   localparam int HDR_LEN = 6;
   localparam int FRAME_OVERHEAD = 10;
   localparam int PLD_START = 9;
   localparam int LEN_W = 9;
   localparam int BYTE_W = 8;
   localparam int PLEN_OUT_W = 6;
   localparam int IDX_OUT_W = 5;
   localparam logic [BYTE_W-1:0] EXPECTED_VERSION_RST = 8'd1;

   localparam logic [BYTE_W-1:0] CHAR_I = 8'h49;
   localparam logic [BYTE_W-1:0] CHAR_M = 8'h4D;
   localparam logic [BYTE_W-1:0] CHAR_P = 8'h50;
   localparam logic [BYTE_W-1:0] CHAR_R = 8'h52;
   localparam logic [BYTE_W-1:0] CHAR_O = 8'h4F;
   localparam logic [BYTE_W-1:0] CHAR_V = 8'h56;

   typedef enum logic [1:0] {
      ST_PARSE,
      ST_READ,
      ST_LOAD
   } ctl_state_type;

   typedef struct packed {
      logic accept;
      logic read_en;
      logic load_drain;
   } ctl_cmd_type;

   typedef struct packed {
      logic header_zone;
      logic will_emit;
      logic run_start;
      logic out_free;
      logic run_last;
   } ctl_status_type;

   function automatic logic [BYTE_W-1:0] hdr_byte(input logic [2:0] pos);
      logic [BYTE_W-1:0] ch;
      case (pos)
         3'd0: ch = CHAR_I;
         3'd1: ch = CHAR_M;
         3'd2: ch = CHAR_P;
         3'd3: ch = CHAR_R;
         3'd4: ch = CHAR_O;
         3'd5: ch = CHAR_V;
         default: ch = CHAR_I;
      endcase
      return ch;
   endfunction

endpackage

FILE: rtl/sfp_ctrl.sv
// Controller of the frame parser: input stall and the payload drain sequence.
module sfp_ctrl
   import sfp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  ctl_status_type st,
   output ctl_cmd_type    cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;
   logic          accept_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_PARSE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      // header bytes never touch the store or the output, so take them during a drain
      accept_ok = st.header_zone ||
                  (state_ff == ST_PARSE && (st.out_free || !st.will_emit));
      req_stall = !accept_ok;
      cmd = '0;
      cmd.accept = req_valid && accept_ok;
      state_in = state_ff;
      unique case (state_ff)
         ST_PARSE: begin
            if (cmd.accept && st.run_start) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read_en = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (st.out_free) begin
               cmd.load_drain = 1'b1;
               state_in = st.run_last ? ST_PARSE : ST_READ;
            end
         end
         default: state_in = ST_PARSE;
      endcase
   end

   a_read_then_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_LOAD)
      else $error("read cycle not followed by load");

   a_drain_accepts_header_only: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && state_ff != ST_PARSE) |-> st.header_zone)
      else $error("non-header byte taken during drain");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && st.will_emit) |-> st.out_free)
      else $error("result byte taken while output busy");

endmodule

FILE: rtl/sfp_datapath.sv
// Datapath of the frame parser: frame counters, checksum, payload store, output register.
module sfp_datapath
   import sfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   input  logic                  csr_write,
   input  logic [BYTE_W-1:0]     csr_expected_version,
   input  ctl_cmd_type           cmd,
   output ctl_status_type        st,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic                  rsp_status,
   output logic [BYTE_W-1:0]     rsp_packet_type,
   output logic [PLEN_OUT_W-1:0] rsp_payload_length,
   output logic [BYTE_W-1:0]     rsp_data_byte,
   output logic [IDX_OUT_W-1:0]  rsp_byte_index,
   output logic                  rsp_last
);

   localparam int FRAME_CAP = FRAME_OVERHEAD + MAX_PAYLOAD;
   localparam int CNT_W = $clog2(FRAME_CAP + 1);
   localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int PLEN_W = $clog2(MAX_PAYLOAD + 1);

   logic [CNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [LEN_W-1:0]  frame_length_ff, frame_length_in;
   logic [BYTE_W-1:0] running_sum_ff, running_sum_in;
   logic [BYTE_W-1:0] version_seen_ff, version_seen_in;
   logic [BYTE_W-1:0] type_seen_ff, type_seen_in;
   logic [BYTE_W-1:0] expected_version_ff;
   logic [BYTE_W-1:0] run_type_ff;
   logic [PLEN_W-1:0] run_len_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [BYTE_W-1:0] rd_data_ff;
   logic [BYTE_W-1:0] store_mem [MAX_PAYLOAD];

   logic                  rsp_valid_ff;
   logic                  rsp_status_ff;
   logic [BYTE_W-1:0]     rsp_packet_type_ff;
   logic [PLEN_OUT_W-1:0] rsp_payload_length_ff;
   logic [BYTE_W-1:0]     rsp_data_byte_ff;
   logic [IDX_OUT_W-1:0]  rsp_byte_index_ff;
   logic                  rsp_last_ff;

   logic [LEN_W-1:0] bc_ext, bc_next, plen_full;
   logic [IDX_W-1:0] wr_idx;
   logic             is_i, in_hunt, in_hdr, at_cap, body, complete, frame_ok, hdr_match;
   logic             restart, emit_bad, emit_empty, run_start, store_we, load_single;
   logic             out_free, run_last;

   always_comb begin
      bc_ext    = LEN_W'(byte_count_ff);
      bc_next   = bc_ext + LEN_W'(1);
      plen_full = frame_length_ff - LEN_W'(FRAME_OVERHEAD);
      wr_idx    = IDX_W'(bc_ext - LEN_W'(PLD_START));
      is_i      = req_rx_byte == CHAR_I;
      in_hunt   = byte_count_ff == '0;
      in_hdr    = bc_ext < LEN_W'(HDR_LEN);
      at_cap    = bc_ext >= LEN_W'(FRAME_CAP);
      body      = !in_hdr && !at_cap;
      hdr_match = req_rx_byte == hdr_byte(byte_count_ff[2:0]);
      complete  = (frame_length_ff != '0) && (bc_next >= frame_length_ff);
      frame_ok  = (version_seen_ff == expected_version_ff) && (running_sum_ff == req_rx_byte);
      restart   = in_hunt || (in_hdr && !hdr_match) || at_cap;
      emit_bad  = at_cap || (body && complete && !frame_ok);
      emit_empty = body && complete && frame_ok && (plen_full == '0);
      run_start = body && complete && frame_ok && (plen_full != '0);
      store_we  = cmd.accept && body && (bc_ext >= LEN_W'(PLD_START)) &&
                  (bc_ext < LEN_W'(PLD_START + MAX_PAYLOAD)) &&
                  (bc_next < frame_length_ff);
      load_single = cmd.accept && (emit_bad || emit_empty);
      out_free  = !rsp_valid_ff || !rsp_stall;
      run_last  = (PLEN_W'(rd_idx_ff) + PLEN_W'(1)) == run_len_ff;

      st.header_zone = bc_ext < LEN_W'(PLD_START);
      st.will_emit   = !in_hdr && (at_cap || complete);
      st.run_start   = run_start;
      st.out_free    = out_free;
      st.run_last    = run_last;
   end

   // frame tracking: hunt, header match, body fields, checksum
   always_comb begin
      byte_count_in   = byte_count_ff;
      frame_length_in = frame_length_ff;
      running_sum_in  = running_sum_ff;
      version_seen_in = version_seen_ff;
      type_seen_in    = type_seen_ff;
      if (restart) begin
         byte_count_in   = is_i ? CNT_W'(1) : '0;
         frame_length_in = '0;
         running_sum_in  = is_i ? req_rx_byte : '0;
      end else if (in_hdr) begin
         byte_count_in  = byte_count_ff + CNT_W'(1);
         running_sum_in = running_sum_ff + req_rx_byte;
      end else begin
         byte_count_in = byte_count_ff + CNT_W'(1);
         if (bc_ext == LEN_W'(HDR_LEN)) begin
            version_seen_in = req_rx_byte;
         end else if (bc_ext == LEN_W'(HDR_LEN + 1)) begin
            type_seen_in = req_rx_byte;
         end else if (bc_ext == LEN_W'(HDR_LEN + 2)) begin
            frame_length_in = LEN_W'(FRAME_OVERHEAD) + LEN_W'(req_rx_byte);
         end
         if (complete) begin
            byte_count_in   = '0;
            frame_length_in = '0;
            running_sum_in  = '0;
         end else begin
            running_sum_in = running_sum_ff + req_rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff       <= '0;
         frame_length_ff     <= '0;
         running_sum_ff      <= '0;
         version_seen_ff     <= '0;
         type_seen_ff        <= '0;
         expected_version_ff <= EXPECTED_VERSION_RST;
      end else begin
         if (cmd.accept) begin
            byte_count_ff   <= byte_count_in;
            frame_length_ff <= frame_length_in;
            running_sum_ff  <= running_sum_in;
            version_seen_ff <= version_seen_in;
            type_seen_ff    <= type_seen_in;
         end
         if (csr_write) begin
            expected_version_ff <= csr_expected_version;
         end
      end
   end

   // drain bookkeeping: latch the packet so the next header may overwrite its fields
   always_ff @(posedge clock) begin
      if (cmd.accept && run_start) begin
         run_type_ff <= type_seen_ff;
         run_len_ff  <= PLEN_W'(plen_full);
         rd_idx_ff   <= '0;
      end else if (cmd.load_drain) begin
         rd_idx_ff <= rd_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[wr_idx] <= req_rx_byte;
      end
      if (cmd.read_en) begin
         rd_data_ff <= store_mem[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_single || cmd.load_drain) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_single) begin
         rsp_status_ff         <= emit_empty;
         rsp_packet_type_ff    <= emit_empty ? type_seen_ff : '0;
         rsp_payload_length_ff <= '0;
         rsp_data_byte_ff      <= '0;
         rsp_byte_index_ff     <= '0;
         rsp_last_ff           <= 1'b1;
      end else if (cmd.load_drain) begin
         rsp_status_ff         <= 1'b1;
         rsp_packet_type_ff    <= run_type_ff;
         rsp_payload_length_ff <= PLEN_OUT_W'(run_len_ff);
         rsp_data_byte_ff      <= rd_data_ff;
         rsp_byte_index_ff     <= IDX_OUT_W'(rd_idx_ff);
         rsp_last_ff           <= run_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_packet_type    = rsp_packet_type_ff;
   assign rsp_payload_length = rsp_payload_length_ff;
   assign rsp_data_byte      = rsp_data_byte_ff;
   assign rsp_byte_index     = rsp_byte_index_ff;
   assign rsp_last           = rsp_last_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      bc_ext <= LEN_W'(FRAME_CAP))
      else $error("byte count beyond frame cap");

   a_length_after_header: assert property (@(posedge clock) disable iff (reset)
      frame_length_ff != '0 |-> bc_ext >= LEN_W'(PLD_START))
      else $error("frame length known too early");

   a_single_load_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.load_drain |-> !load_single)
      else $error("drain load collides with single result");

endmodule

FILE: rtl/serial_provision_frame_parser_top.sv
// Top level of the serial provisioning frame parser: controller plus datapath.
//
// Usage: feed one received serial byte per item on req_ (req_valid, req_stall,
// req_rx_byte). The parser hunts for the header IMPROV, then takes version,
// type, length, payload and checksum bytes. Results leave on rsp_ as items:
// one per payload byte of a good frame, one with empty payload fields for a
// good empty frame, or one invalid item (status 0) for a bad checksum, a wrong
// version or a declared length larger than the payload store.
// A single result is shown the cycle after the frame's last byte is taken.
// A payload run drains from the store item by item, each with a registered
// store read and then a load of the output register, which waits while the
// receiver stalls. Bytes are taken one per cycle while not stalled; during
// a drain only the next frame's header, version, type and length bytes enter.
// A receiver stall holds the output register; the input then stalls for bytes
// that would produce a result and, while a drain waits, for payload bytes.
// Reset clears the frame tracking and output valid and sets expected_version
// to 1; the store needs no clearing. csr_ writes set expected_version and are
// always ready; write them only while the parser is idle.
module serial_provision_frame_parser_top
   import sfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BYTE_W-1:0]     req_rx_byte,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [BYTE_W-1:0]     csr_expected_version,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_status,
   output logic [BYTE_W-1:0]     rsp_packet_type,
   output logic [PLEN_OUT_W-1:0] rsp_payload_length,
   output logic [BYTE_W-1:0]     rsp_data_byte,
   output logic [IDX_OUT_W-1:0]  rsp_byte_index,
   output logic                  rsp_last
);

   ctl_cmd_type    cmd;
   ctl_status_type st;

   // register writes are always taken
   assign csr_ready = 1'b1;

   sfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   sfp_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_rx_byte          (req_rx_byte),
      .csr_write            (csr_valid && csr_ready),
      .csr_expected_version (csr_expected_version),
      .cmd                  (cmd),
      .st                   (st),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_packet_type      (rsp_packet_type),
      .rsp_payload_length   (rsp_payload_length),
      .rsp_data_byte        (rsp_data_byte),
      .rsp_byte_index       (rsp_byte_index),
      .rsp_last             (rsp_last)
   );

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench of the serial provisioning frame parser, driven with framed byte traffic.
module testbench;
   import sfp_pkg::*;

   typedef logic [BYTE_W-1:0] byte_type;

   // One result item as it leaves the rsp_ channel.
   typedef struct packed {
      logic                  status;
      byte_type              pkt_type;
      logic [PLEN_OUT_W-1:0] plen;
      byte_type              data;
      logic [IDX_OUT_W-1:0]  idx;
      logic                  last;
   } parse_result_type;

   localparam int FRAME_CAP = FRAME_OVERHEAD + MAX_PAYLOAD_DEF;
   localparam logic [HDR_LEN*BYTE_W-1:0] HEADER_TEXT =
      {CHAR_I, CHAR_M, CHAR_P, CHAR_R, CHAR_O, CHAR_V};
   localparam int CYCLE_LIMIT    = 300000;
   localparam int SETTLE_CYCLES  = 100;   // longest drain is 32 items, each a store read and an output load
   localparam int HOLDOFF_CYCLES = 200;
   localparam int PRINT_LIMIT    = 30;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   byte_type              req_rx_byte;
   logic                  csr_valid;
   logic                  csr_ready;
   byte_type              csr_expected_version;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_status;
   byte_type              rsp_packet_type;
   logic [PLEN_OUT_W-1:0] rsp_payload_length;
   byte_type              rsp_data_byte;
   logic [IDX_OUT_W-1:0]  rsp_byte_index;
   logic                  rsp_last;

   // Frame tracker: our own copy of the parser state and of the version register.
   logic [5:0]       trk_count;
   logic [LEN_W-1:0] trk_length;
   byte_type         trk_sum;
   byte_type         trk_version;
   byte_type         trk_type;
   byte_type         trk_payload [MAX_PAYLOAD_DEF];
   byte_type         ver_setting;

   parse_result_type pending_results [$];
   byte_type         frame_body [$];

   int cycle_count     = 0;
   int error_count     = 0;
   int bytes_sent      = 0;
   int payload_items   = 0;
   int empty_packets   = 0;
   int invalid_frames  = 0;
   bit idling_on;
   bit holdoff_request;

   serial_provision_frame_parser_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_expected_version (csr_expected_version),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_packet_type      (rsp_packet_type),
      .rsp_payload_length   (rsp_payload_length),
      .rsp_data_byte        (rsp_data_byte),
      .rsp_byte_index       (rsp_byte_index),
      .rsp_last             (rsp_last)
   );

   always #5 clock = ~clock;

   // Stop a hung run: a lost result would otherwise wait forever.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding.",
                  cycle_count, pending_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic byte_type header_char(input int k);
      return HEADER_TEXT[(HDR_LEN-1-k)*BYTE_W +: BYTE_W];
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
   endfunction

   function automatic parse_result_type make_result(input logic st, input byte_type ty,
                                                    input int plen, input byte_type d,
                                                    input int idx, input logic lst);
      parse_result_type r;
      r.status   = st;
      r.pkt_type = ty;
      r.plen     = PLEN_OUT_W'(plen);
      r.data     = d;
      r.idx      = IDX_OUT_W'(idx);
      r.last     = lst;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("MISMATCH cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_field(input string name, input byte_type got, input byte_type want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   task automatic clear_hunt();
      trk_count  = '0;
      trk_length = '0;
      trk_sum    = '0;
   endtask

   // Drop the frame; an 'I' opens a new one.
   task automatic restart_hunt(input byte_type b);
      clear_hunt();
      if (b == CHAR_I) begin
         trk_count = 6'd1;
         trk_sum   = b;
      end
   endtask

   // Advance the tracker by one accepted byte and queue the results it causes.
   task automatic track_frame_byte(input byte_type b);
      int   pos;
      int   plen;
      int   k;
      logic good;
      if (trk_count == 0) begin
         restart_hunt(b);
      end else if (trk_count < HDR_LEN) begin
         if (b != header_char(int'(trk_count))) begin
            restart_hunt(b);
         end else begin
            trk_sum   = trk_sum + b;
            trk_count = trk_count + 6'd1;
         end
      end else if (trk_count >= FRAME_CAP) begin
         // declared length overran the store: this byte closes it as invalid
         restart_hunt(b);
         pending_results.push_back(make_result(1'b0, '0, 0, '0, 0, 1'b1));
      end else begin
         pos       = int'(trk_count);
         trk_count = trk_count + 6'd1;
         if (pos == HDR_LEN)
            trk_version = b;
         else if (pos == HDR_LEN + 1)
            trk_type = b;
         else if (pos == PLD_START - 1)
            trk_length = LEN_W'(FRAME_OVERHEAD + int'(b));
         else if (pos + 1 < int'(trk_length) && pos - PLD_START < MAX_PAYLOAD_DEF)
            trk_payload[pos - PLD_START] = b;

         if (trk_length == 0 || trk_count < trk_length) begin
            trk_sum = trk_sum + b;
         end else begin
            // b is the checksum byte
            good = (trk_version == ver_setting) && (trk_sum == b);
            plen = int'(trk_length) - FRAME_OVERHEAD;
            clear_hunt();
            if (!good) begin
               pending_results.push_back(make_result(1'b0, '0, 0, '0, 0, 1'b1));
            end else if (plen == 0) begin
               pending_results.push_back(make_result(1'b1, trk_type, 0, '0, 0, 1'b1));
            end else begin
               for (k = 0; k < plen && k < MAX_PAYLOAD_DEF; k++)
                  pending_results.push_back(make_result(1'b1, trk_type, plen,
                                                        trk_payload[k], k, k + 1 == plen));
            end
         end
      end
   endtask

   // Sample handshakes at the rising edge, before the block's registers move.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         track_frame_byte(req_rx_byte);
   end

   always @(posedge clock) begin : result_checker
      parse_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with none expected: status %0d type %0h idx %0d",
                                      rsp_status, rsp_packet_type, rsp_byte_index));
         end else begin
            want = pending_results.pop_front();
            check_field("status", BYTE_W'(rsp_status), BYTE_W'(want.status));
            check_field("packet_type", rsp_packet_type, want.pkt_type);
            check_field("payload_length", BYTE_W'(rsp_payload_length), BYTE_W'(want.plen));
            check_field("data_byte", rsp_data_byte, want.data);
            check_field("byte_index", BYTE_W'(rsp_byte_index), BYTE_W'(want.idx));
            check_field("last", BYTE_W'(rsp_last), BYTE_W'(want.last));
            if (!want.status)
               invalid_frames++;
            else if (want.plen == 0)
               empty_packets++;
            else
               payload_items++;
         end
      end
   end

   // Receiver side: random stall bursts while idling is on; a requested
   // holdoff is counted down here while the sender keeps going.
   initial begin : rsp_stall_driver
      int left;
      left      = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_request) begin
            holdoff_request = 1'b0;
            left = HOLDOFF_CYCLES;
         end else if (left == 0 && idling_on && $urandom_range(0, 99) < 25) begin
            left = pick_gap();
         end
         if (left > 0) begin
            rsp_stall <= 1'b1;
            left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one byte and hold it until accepted; valid stays high on exit.
   task automatic send_byte(input byte_type b);
      int gap;
      gap = 0;
      if (idling_on && $urandom_range(0, 99) < 30)
         gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic fill_body(input int n);
      repeat (n) frame_body.push_back(byte_type'($urandom_range(0, 255)));
   endtask

   // Send header, version, type, length and the queued body; close with the
   // checksum (xor corrupt) unless the frame is to be left open.
   task automatic send_frame(input byte_type ver, input byte_type ptype,
                             input byte_type len_byte, input byte_type corrupt,
                             input bit close);
      byte_type sum;
      int       k;
      sum = '0;
      for (k = 0; k < HDR_LEN; k++) begin
         sum = sum + header_char(k);
         send_byte(header_char(k));
      end
      sum = sum + ver + ptype + len_byte;
      send_byte(ver);
      send_byte(ptype);
      send_byte(len_byte);
      for (k = 0; k < frame_body.size(); k++) begin
         sum = sum + frame_body[k];
         send_byte(frame_body[k]);
      end
      frame_body.delete();
      if (close)
         send_byte(sum ^ corrupt);
   endtask

   // Drop valid, wait out every expected result, then let the pipe settle.
   task automatic drain_and_settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_version(input byte_type v);
      @(negedge clock);
      csr_valid            <= 1'b1;
      csr_expected_version <= v;
      do @(posedge clock); while (!csr_ready);
      ver_setting = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Line noise before a header, then the shortest good frames.
   task automatic test_noise_and_short_frames();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CHAR_M);
      send_frame(ver_setting, 8'h00, 8'd0, 8'h00, 1'b1);
      frame_body.push_back(8'hFF);
      send_frame(ver_setting, 8'hFF, 8'd1, 8'h00, 1'b1);
   endtask

   // Broken headers: a stray 'I' restarts the hunt, any other byte drops it.
   task automatic test_header_restart();
      send_byte(CHAR_I);
      send_byte(CHAR_M);
      send_byte(CHAR_I);
      send_byte(CHAR_M);
      send_byte(CHAR_P);
      send_byte(8'h58);
      fill_body(2);
      send_frame(ver_setting, 8'h3C, 8'd2, 8'h00, 1'b1);
   endtask

   // Bad checksum, then wrong version.
   task automatic test_bad_frames();
      fill_body(1);
      send_frame(ver_setting, 8'h11, 8'd1, 8'h01, 1'b1);
      send_frame(ver_setting ^ 8'h80, 8'h22, 8'd0, 8'h00, 1'b1);
   endtask

   // Full store, then a length past the store cut off at the cap by the next header.
   task automatic test_payload_limits();
      int k;
      for (k = 0; k < MAX_PAYLOAD_DEF; k++)
         frame_body.push_back(k[0] ? 8'hFF : 8'h00);
      send_frame(ver_setting, 8'h5A, byte_type'(MAX_PAYLOAD_DEF), 8'h00, 1'b1);
      fill_body(MAX_PAYLOAD_DEF + 1);
      send_frame(ver_setting, 8'h77, 8'd255, 8'h00, 1'b0);
      send_frame(ver_setting, 8'hA5, 8'd0, 8'h00, 1'b1);
   endtask

   // Version register at both extremes; the old version must now fail.
   task automatic test_version_register();
      drain_and_settle();
      write_version(8'h00);
      send_frame(8'h00, 8'h01, 8'd0, 8'h00, 1'b1);
      send_frame(EXPECTED_VERSION_RST, 8'h02, 8'd0, 8'h00, 1'b1);
      drain_and_settle();
      write_version(8'hFF);
      send_frame(8'hFF, 8'h03, 8'd0, 8'h00, 1'b1);
   endtask

   // Mostly well-formed frames with random content; the rest noise,
   // truncated headers and overlong frames.
   task automatic test_random_traffic(input int budget);
      int       first;
      int       pick;
      int       len;
      int       k;
      byte_type ver;
      byte_type corrupt;
      first = bytes_sent;
      while (bytes_sent - first < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6)
                                             : $urandom_range(7, MAX_PAYLOAD_DEF);
            ver = ($urandom_range(0, 9) < 8) ? ver_setting
                                             : byte_type'($urandom_range(0, 255));
            corrupt = ($urandom_range(0, 9) < 9) ? 8'h00 : byte_type'($urandom_range(1, 255));
            fill_body(len);
            send_frame(ver, byte_type'($urandom_range(0, 255)), byte_type'(len),
                       corrupt, 1'b1);
         end else if (pick < 82) begin
            repeat ($urandom_range(1, 4))
               send_byte($urandom_range(0, 1) ? CHAR_I : byte_type'($urandom_range(0, 255)));
         end else if (pick < 94) begin
            len = $urandom_range(1, HDR_LEN - 1);
            for (k = 0; k < len; k++)
               send_byte(header_char(k));
            send_byte(byte_type'($urandom_range(0, 255)));
         end else begin
            fill_body(MAX_PAYLOAD_DEF + 1);
            send_frame(ver_setting, byte_type'($urandom_range(0, 255)),
                       byte_type'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)), 8'h00,
                       $urandom_range(0, 1) != 0);
         end
      end
   endtask

   // Hold the receiver off while frames keep coming, so the parser backs up
   // into its input.
   task automatic test_output_holdoff();
      int n;
      idling_on       = 1'b0;
      holdoff_request = 1'b1;
      for (n = 0; n < 2; n++) begin
         fill_body(4);
         send_frame(ver_setting, byte_type'($urandom_range(0, 255)), 8'd4, 8'h00, 1'b1);
      end
      idling_on = 1'b1;
   endtask

   initial begin
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_rx_byte          = '0;
      csr_valid            = 1'b0;
      csr_expected_version = '0;
      idling_on            = 1'b1;
      holdoff_request      = 1'b0;
      ver_setting          = EXPECTED_VERSION_RST;
      trk_version          = '0;
      trk_type             = '0;
      clear_hunt();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, starting at the reset version
      test_noise_and_short_frames();
      test_header_restart();
      test_bad_frames();
      test_payload_limits();
      test_version_register();

      // random part at a random version setting
      drain_and_settle();
      write_version(byte_type'($urandom_range(2, 254)));
      test_random_traffic(10);

      test_output_holdoff();
      drain_and_settle();

      $display("Sent %0d bytes; checked %0d payload items, %0d empty packets, %0d invalid frames.",
               bytes_sent, payload_items, empty_packets, invalid_frames);
      $display("Version register ran at reset value, 0x00, 0xFF and random; one %0d-cycle holdoff.",
               HOLDOFF_CYCLES);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: files.f
rtl/sfp_pkg.sv
rtl/sfp_ctrl.sv
rtl/sfp_datapath.sv
rtl/serial_provision_frame_parser_top.sv
tb/sv/testbench.sv
